// File: rtl/double_ended_queue_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue
// Shared wrappers that keep the concurrent checks short and uniform.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define DEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that forces a consequence at the next clock edge.
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Widths, operation and status codes, and the command that steers the cells.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;
    localparam int MODE_W    = 3;
    localparam int STATUS_W  = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DUMP       = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // At most one field is set in any cycle.
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
        logic rotate;
    } t_cell_cmd;

endpackage

// File: rtl/deq_cell.sv
// ----------------------------------------------------------------------------
// Deque storage cell
// Holds one word and its occupied flag, and moves it to or from a neighbor.
// ----------------------------------------------------------------------------
module deq_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  deq_pkg::t_cell_cmd         i_cmd,
    input  logic [deq_pkg::WORD_W-1:0] i_prev_data,
    input  logic                       i_prev_valid,
    input  logic [deq_pkg::WORD_W-1:0] i_next_data,
    input  logic                       i_next_valid,
    input  logic [deq_pkg::WORD_W-1:0] i_push_value,
    input  logic [deq_pkg::WORD_W-1:0] i_head_data,
    output logic [deq_pkg::WORD_W-1:0] o_data,
    output logic                       o_valid,
    output logic                       o_is_back
);
    import deq_pkg::*;

    logic [WORD_W-1:0] r_data;
    logic [WORD_W-1:0] n_data;
    logic              r_valid;
    logic              n_valid;
    logic              is_back;

    // The back cell is the last occupied one in the row.
    assign is_back = r_valid && !i_next_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_cmd.push_front) begin
            n_data  = i_prev_data;
            n_valid = i_prev_valid;
        end else if (i_cmd.pop_front) begin
            n_data  = i_next_data;
            n_valid = i_next_valid;
        end else if (i_cmd.push_back) begin
            if (!r_valid && i_prev_valid) begin
                n_data  = i_push_value;
                n_valid = 1'b1;
            end
        end else if (i_cmd.pop_back) begin
            if (is_back) begin
                n_valid = 1'b0;
            end
        end else if (i_cmd.rotate) begin
            // The front word wraps around to the back; the rest move forward.
            if (is_back) begin
                n_data = i_head_data;
            end else if (r_valid) begin
                n_data = i_next_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data    = r_data;
    assign o_valid   = r_valid;
    assign o_is_back = is_back;

endmodule

// File: rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// Deque sequencer
// Decodes each operation, steers the cell row and registers the result beats.
// ----------------------------------------------------------------------------
module deq_ctrl #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic [deq_pkg::MODE_W-1:0]   i_mode,
    input  logic [deq_pkg::WORD_W-1:0]   i_head_data,
    input  logic [deq_pkg::WORD_W-1:0]   i_back_data,
    input  logic                         i_empty,
    input  logic                         i_full,
    output logic                         busy,
    output deq_pkg::t_cell_cmd           o_cmd,
    output logic                         o_strobe,
    output logic [deq_pkg::WORD_W-1:0]   o_out_value,
    output logic [deq_pkg::STATUS_W-1:0] o_status,
    output logic                         o_last
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {S_IDLE, S_DUMP} t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_remain;
    logic                r_strobe;
    logic [WORD_W-1:0]   r_out_value;
    logic [STATUS_W-1:0] r_status;
    logic                r_last;
    logic                accept;
    t_cell_cmd           cmd;

    assign busy   = (r_state == S_DUMP);
    assign accept = start && !busy;

    always_comb begin
        cmd = '0;
        if (busy) begin
            cmd.rotate = 1'b1;
        end else if (accept) begin
            case (i_mode)
                MODE_PUSH_FRONT: cmd.push_front = !i_full;
                MODE_PUSH_BACK:  cmd.push_back  = !i_full;
                MODE_POP_FRONT:  cmd.pop_front  = !i_empty;
                MODE_POP_BACK:   cmd.pop_back   = !i_empty;
                MODE_DUMP:       cmd.rotate     = !i_empty;
                default:         cmd = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_remain <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_out_value <= '0;
                        r_status    <= STAT_OK;
                        r_last      <= 1'b1;
                        case (i_mode)
                            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                                r_strobe <= 1'b1;
                                if (i_full) begin
                                    r_status <= STAT_FULL;
                                end else begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end
                            MODE_POP_FRONT, MODE_POP_BACK: begin
                                r_strobe <= 1'b1;
                                if (i_empty) begin
                                    r_status <= STAT_EMPTY;
                                end else begin
                                    r_count     <= r_count - CNT_W'(1);
                                    r_out_value <= (i_mode == MODE_POP_FRONT) ?
                                                   i_head_data : i_back_data;
                                end
                            end
                            MODE_DUMP: begin
                                r_strobe <= 1'b1;
                                if (i_empty) begin
                                    r_status <= STAT_EMPTY;
                                end else begin
                                    r_out_value <= i_head_data;
                                    r_remain    <= r_count - CNT_W'(1);
                                    if (r_count != CNT_W'(1)) begin
                                        r_last  <= 1'b0;
                                        r_state <= S_DUMP;
                                    end
                                end
                            end
                            default: begin
                                r_strobe <= 1'b0;
                            end
                        endcase
                    end
                end
                S_DUMP: begin
                    r_strobe    <= 1'b1;
                    r_out_value <= i_head_data;
                    r_status    <= STAT_OK;
                    r_last      <= (r_remain == CNT_W'(1));
                    r_remain    <= r_remain - CNT_W'(1);
                    if (r_remain == CNT_W'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cmd       = cmd;
    assign o_strobe    = r_strobe;
    assign o_out_value = r_out_value;
    assign o_status    = r_status;
    assign o_last      = r_last;

endmodule

// File: rtl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed 32-bit words built as a row of shifting cells.
// ----------------------------------------------------------------------------
// An operation is taken on a clock edge where start is high and busy is low.
// Every result beat appears on the output ports for exactly one cycle with
// o_strobe high; the first beat comes in the cycle after the operation is
// taken; the receiver cannot stall, so it must take each beat when the
// strobe is up. Pushes and pops produce one beat. A dump of N stored words
// produces N beats on consecutive cycles, front to back, with o_last on the
// back word; busy stays high after the dump is taken while the cell row
// rotates its contents one position per cycle and comes back to its
// original order. An empty dump gives one beat. Modes five to seven are
// taken and ignored without a beat. There is no clearing pass after reset:
// the occupied flags of the cells are cleared at once.
// ----------------------------------------------------------------------------
`include "double_ended_queue_top_macros.svh"

module double_ended_queue_top #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [deq_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [deq_pkg::WORD_W-1:0]   i_push_value,
    output logic                                o_strobe,
    output logic signed [deq_pkg::WORD_W-1:0]   o_out_value,
    output logic [deq_pkg::STATUS_W-1:0]        o_status,
    output logic                                o_last
);
    import deq_pkg::*;

    // Cell zero always holds the front word; the occupied cells form an
    // unbroken run starting at cell zero, so the last occupied cell is the back.
    logic [WORD_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]  cell_valid;
    logic [DEPTH-1:0]  cell_is_back;
    logic [WORD_W-1:0] back_data;
    logic [WORD_W-1:0] out_value;
    t_cell_cmd         cmd;

    // At most one cell flags itself as the back (none when empty), so an AND-OR picks its word.
    always_comb begin
        back_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            back_data = back_data | (cell_is_back[i] ? cell_data[i] : '0);
        end
    end

    deq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_mode      (i_mode),
        .i_head_data (cell_data[0]),
        .i_back_data (back_data),
        .i_empty     (!cell_valid[0]),
        .i_full      (cell_valid[DEPTH-1]),
        .busy        (busy),
        .o_cmd       (cmd),
        .o_strobe    (o_strobe),
        .o_out_value (out_value),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    assign o_out_value = out_value;

    // The row: each cell sees its neighbor toward the front (prev) and toward
    // the back (next). A front push enters at the front end of the row; a back push fills the first free cell.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_W-1:0] prev_data;
        logic              prev_valid;
        logic [WORD_W-1:0] next_data;
        logic              next_valid;

        if (g == 0) begin : g_front
            assign prev_data  = i_push_value;
            assign prev_valid = 1'b1;
        end else begin : g_mid
            assign prev_data  = cell_data[g-1];
            assign prev_valid = cell_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_end
            assign next_data  = '0;
            assign next_valid = 1'b0;
        end else begin : g_inner
            assign next_data  = cell_data[g+1];
            assign next_valid = cell_valid[g+1];
        end

        deq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_prev_data  (prev_data),
            .i_prev_valid (prev_valid),
            .i_next_data  (next_data),
            .i_next_valid (next_valid),
            .i_push_value (i_push_value),
            .i_head_data  (cell_data[0]),
            .o_data       (cell_data[g]),
            .o_valid      (cell_valid[g]),
            .o_is_back    (cell_is_back[g])
        );
    end

    // The occupied cells must always be packed against the front.
    `DEQ_ASSERT(a_packed, i_clk, i_rst_n, ((cell_valid & (cell_valid + 1'b1)) == '0), "deque cells not packed at the front")

    // A dump in progress emits a beat on every following cycle.
    `DEQ_ASSERT_NEXT(a_dump_beats, i_clk, i_rst_n, busy, o_strobe, "missing beat during dump")

    // Any operation other than a dump leaves the block ready again.
    `DEQ_ASSERT_NEXT(a_single_beat, i_clk, i_rst_n, (start && !busy && (i_mode != MODE_DUMP)), !busy, "busy after a single-beat operation")

endmodule
